>>> hdl/ogmi_pkg.sv
// Shared types and constants for the occupancy grid mark and inflate unit.
package ogmi_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPM        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFL_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INFL_RAD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_EN    = 3'd4;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_BASE  = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] CELL_OCCUPIED = 8'd100;
    localparam logic [7:0] CELL_FREE     = 8'd0;
    localparam logic [7:0] CELL_UNKNOWN  = 8'hFF;

    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AREA,
        ST_BASE,
        ST_PX,
        ST_PY,
        ST_PCY,
        ST_PADDR,
        ST_PWR,
        ST_RCHK,
        ST_DIV,
        ST_WIN,
        ST_WMUL,
        ST_WSTART,
        ST_SCAN,
        ST_RAW_RD,
        ST_RES
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

>>> hdl/ogmi_grid_ram.sv
// Cell memory of the grid: one write port, one read port with registered data.
module ogmi_grid_ram
    import ogmi_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ogmi_mul.sv
// Shared registered signed multiplier.
module ogmi_mul
    import ogmi_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> hdl/ogmi_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ogmi_div
    import ogmi_pkg::*;
#(
    parameter int AW = 12,
    parameter int SW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [AW-1:0] o_quotient,
    output logic [SW-1:0] o_remainder
);

    localparam int CNT_W = $clog2(AW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_quo;
    logic [SW-1:0]    r_rem;
    logic [SW:0]      w_sh;
    logic [SW:0]      w_diff;
    logic             w_ge;

    assign w_sh   = {r_rem, r_quo[AW-1]};
    assign w_ge   = (w_sh >= {1'b0, i_divisor});
    assign w_diff = w_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(AW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[AW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[SW-1:0] : w_sh[SW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> hdl/occupancy_grid_mark_and_inflate_unit.sv
// Top level: occupancy grid with obstacle marking and read-time inflation.
//
//  channel | direction | handshake                  | payload
//  cfg     | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_stall    | i_op, i_point_x, i_point_y,
//          |           |                            | i_base_value, i_read_index
//  out     | out       | o_out_valid / i_out_stall  | o_cell_value
//
// One item at a time. After reset and after each clear item a clearing sweep
// writes one cell a cycle over all GRID_SIDE*GRID_SIDE cells, taking no item meanwhile.
// Base item: area product, then the write. Point item: x, y and row address through
// the shared multiplier, then the write. Read item: area product, range check, then a
// plain read (none out of range); inflated it adds the divider and a window cell scan.
// The output register lets the next item in while a result waits on i_out_stall.
module occupancy_grid_mark_and_inflate_unit
    import ogmi_pkg::*;
#(
    parameter int GRID_SIDE   = 64,
    parameter int MAX_INFLATE = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_op,
    input  logic signed [15:0]    i_point_x,
    input  logic signed [15:0]    i_point_y,
    input  logic signed [7:0]     i_base_value,
    input  logic [11:0]           i_read_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [7:0]     o_cell_value
);

    localparam int CELLS    = GRID_SIDE * GRID_SIDE;
    localparam int AW       = $clog2(CELLS);
    localparam int SW       = $clog2(GRID_SIDE + 1);
    localparam int CW       = $clog2(GRID_SIDE);
    localparam int EW       = $clog2(MAX_INFLATE + 1);
    localparam int WW       = SW + 2;
    localparam int SIDE_RST = (GRID_SIDE < 64) ? GRID_SIDE : 64;
    localparam int RAD_RST  = (MAX_INFLATE < 2) ? MAX_INFLATE : 2;

    // configuration, stored already clamped
    logic [SW-1:0] r_side;
    logic [15:0]   r_cpm;
    logic          r_infl_en;
    logic [EW-1:0] r_radius;
    logic          r_base_en;

    t_state        r_state;
    t_state        n_state;

    logic [AW-1:0] r_clr_addr;
    logic [AW:0]   r_base_ptr;
    logic          r_out_valid;
    logic [7:0]    r_out_value;
    logic          r_hit;
    logic          r_scan_pend;

    logic [1:0]          r_op;
    logic signed [15:0]  r_point_x;
    logic signed [15:0]  r_point_y;
    logic [7:0]          r_base_value;
    logic [11:0]         r_read_index;
    logic                r_oor;
    logic [CW-1:0]       r_cx;
    logic [CW-1:0]       r_cy;
    logic                r_x_ok;
    logic                r_y_ok;
    logic [CW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       r_r0;
    logic [CW-1:0]       r_r1;
    logic [CW-1:0]       r_c0;
    logic [CW-1:0]       r_c1;
    logic [CW-1:0]       r_rr;
    logic [CW-1:0]       r_cc;
    logic [AW-1:0]       r_base;

    logic                      w_accept;
    logic                      w_out_load;
    t_mem_ctl                  w_mem_ctl;
    logic [AW-1:0]             w_waddr;
    logic [7:0]                w_wdata;
    logic [AW-1:0]             w_raddr;
    logic [7:0]                w_rdata;
    logic signed [MUL_W-1:0]   w_mul_a;
    logic signed [MUL_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [AW-1:0]             w_quo;
    logic [SW-1:0]             w_rem;
    logic signed [34:0]        w_v;
    logic signed [34:0]        w_vr;
    logic [18:0]               w_cell;
    logic                      w_cell_ok;
    logic                      w_oor;
    logic                      w_base_ok;
    logic                      w_scan_last;
    logic [8:0]                w_side_raw;
    logic [SW-1:0]             w_side_in;
    logic [EW-1:0]             w_rad_in;
    logic [AW-1:0]             w_idx;
    logic [CW-1:0]             w_side_m1;

    function automatic logic [CW-1:0] win_lo(input logic [CW-1:0] p, input logic [EW-1:0] e);
        logic [WW-1:0] v;
        v = WW'(p) + WW'(1);
        return (v > WW'(e)) ? CW'(v - WW'(e)) : '0;
    endfunction

    function automatic logic [CW-1:0] win_hi(input logic [CW-1:0] p, input logic [EW-1:0] e,
                                             input logic [CW-1:0] lim);
        logic [WW-1:0] v;
        v = WW'(p) + WW'(e);
        return (v > WW'(lim)) ? lim : CW'(v);
    endfunction

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == ST_RES) && (!r_out_valid || !i_out_stall);
    assign w_idx      = AW'(r_read_index);
    assign w_side_m1  = CW'(r_side - 1'b1);

    assign w_side_raw = 9'(i_cfg_data[6:0]);
    assign w_side_in  = (w_side_raw == 9'd0) ? SW'(1) :
                        (w_side_raw > 9'(GRID_SIDE)) ? SW'(GRID_SIDE) : SW'(w_side_raw);
    assign w_rad_in   = (5'(i_cfg_data[3:0]) > 5'(MAX_INFLATE)) ? EW'(MAX_INFLATE)
                                                               : EW'(i_cfg_data[3:0]);

    // metric to cell, rounding halves up
    assign w_v       = 35'(w_prod) + 35'($signed({1'b0, r_side, 15'd0}));
    assign w_vr      = w_v + 35'sd32768;
    assign w_cell    = w_vr[34:16];
    assign w_cell_ok = !w_vr[34] && (w_vr != 35'sd0) && (w_cell < 19'(r_side));

    assign w_oor     = (PROD_W'(r_read_index) >= w_prod);
    assign w_base_ok = r_base_en && (r_base_ptr < w_prod[AW:0]);
    assign w_scan_last = (r_cc == r_c1) && (r_rr == r_r1);

    ogmi_grid_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ogmi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    ogmi_div #(
        .AW (AW),
        .SW (SW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_idx),
        .i_divisor   (r_side),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(CELLS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_op)
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_POINT: n_state = ST_PX;
                        default:  n_state = ST_AREA;
                    endcase
                end
            end
            ST_AREA:   n_state = (r_op == OP_BASE) ? ST_BASE : ST_RCHK;
            ST_BASE:   n_state = ST_IDLE;
            ST_PX:     n_state = ST_PY;
            ST_PY:     n_state = ST_PCY;
            ST_PCY:    n_state = ST_PADDR;
            ST_PADDR:  n_state = ST_PWR;
            ST_PWR:    n_state = ST_IDLE;
            ST_RCHK: begin
                priority if (w_oor)                            n_state = ST_RES;
                else if (!r_infl_en || (r_radius == '0))       n_state = ST_RAW_RD;
                else                                           n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) n_state = ST_WIN;
            end
            ST_WIN:    n_state = ST_WMUL;
            ST_WMUL:   n_state = ST_WSTART;
            ST_WSTART: n_state = ST_SCAN;
            ST_SCAN: begin
                if (w_scan_last) n_state = ST_RAW_RD;
            end
            ST_RAW_RD: n_state = ST_RES;
            ST_RES: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        w_mem_ctl   = '0;
        w_waddr     = r_clr_addr;
        w_wdata     = CELL_FREE;
        w_raddr     = w_idx;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_ctl.we = 1'b1;
            end
            ST_AREA: begin
                w_mul_a = MUL_W'($signed({1'b0, r_side}));
                w_mul_b = MUL_W'($signed({1'b0, r_side}));
            end
            ST_BASE: begin
                w_mem_ctl.we = w_base_ok;
                w_waddr      = r_base_ptr[AW-1:0];
                w_wdata      = r_base_value;
            end
            ST_PX: begin
                w_mul_a = MUL_W'(r_point_x);
                w_mul_b = $signed({1'b0, r_cpm});
            end
            ST_PY: begin
                w_mul_a = MUL_W'(r_point_y);
                w_mul_b = $signed({1'b0, r_cpm});
            end
            ST_PADDR: begin
                w_mul_a = MUL_W'($signed({1'b0, r_cy}));
                w_mul_b = MUL_W'($signed({1'b0, r_side}));
            end
            ST_PWR: begin
                w_mem_ctl.we = r_x_ok && r_y_ok;
                w_waddr      = w_prod[AW-1:0] + AW'(r_cx);
                w_wdata      = CELL_OCCUPIED;
            end
            ST_RCHK: begin
                w_div_start = !w_oor && r_infl_en && (r_radius != '0);
            end
            ST_WMUL: begin
                w_mul_a = MUL_W'($signed({1'b0, r_r0}));
                w_mul_b = MUL_W'($signed({1'b0, r_side}));
            end
            ST_SCAN: begin
                w_mem_ctl.re = 1'b1;
                w_raddr      = r_base + AW'(r_cc);
            end
            ST_RAW_RD: begin
                w_mem_ctl.re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_base_ptr  <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_scan_pend <= 1'b0;
            r_side      <= SW'(SIDE_RST);
            r_cpm       <= 16'd2560;
            r_infl_en   <= 1'b0;
            r_radius    <= EW'(RAD_RST);
            r_base_en   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_pend <= (r_state == ST_SCAN);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SIDE:     r_side    <= w_side_in;
                    CFG_CPM:      r_cpm     <= i_cfg_data;
                    CFG_INFL_EN:  r_infl_en <= i_cfg_data[0];
                    CFG_INFL_RAD: r_radius  <= w_rad_in;
                    CFG_BASE_EN:  r_base_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_accept && (i_op == OP_CLEAR)) begin
                r_clr_addr <= '0;
                r_base_ptr <= '0;
            end
            if ((r_state == ST_BASE) && w_base_ok) begin
                r_base_ptr <= r_base_ptr + 1'b1;
            end
            if (w_accept) begin
                r_hit <= 1'b0;
            end else if (r_scan_pend && (w_rdata == CELL_OCCUPIED)) begin
                r_hit <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op         <= i_op;
            r_point_x    <= i_point_x;
            r_point_y    <= i_point_y;
            r_base_value <= i_base_value;
            r_read_index <= i_read_index;
        end
        if (r_state == ST_PY) begin
            r_cx   <= w_cell[CW-1:0];
            r_x_ok <= w_cell_ok;
        end
        if (r_state == ST_PCY) begin
            r_cy   <= w_cell[CW-1:0];
            r_y_ok <= w_cell_ok;
        end
        if (r_state == ST_RCHK) begin
            r_oor <= w_oor;
        end
        if (w_div_done) begin
            r_row <= w_quo[CW-1:0];
            r_col <= w_rem[CW-1:0];
        end
        if (r_state == ST_WIN) begin
            r_r0 <= win_lo(r_row, r_radius);
            r_r1 <= win_hi(r_row, r_radius, w_side_m1);
            r_c0 <= win_lo(r_col, r_radius);
            r_c1 <= win_hi(r_col, r_radius, w_side_m1);
        end
        if (r_state == ST_WSTART) begin
            r_base <= w_prod[AW-1:0];
            r_rr   <= r_r0;
            r_cc   <= r_c0;
        end
        if (r_state == ST_SCAN) begin
            if (r_cc == r_c1) begin
                r_cc   <= r_c0;
                r_rr   <= r_rr + 1'b1;
                r_base <= r_base + AW'(r_side);
            end else begin
                r_cc <= r_cc + 1'b1;
            end
        end
        if (w_out_load) begin
            r_out_value <= r_oor ? CELL_UNKNOWN : (r_hit ? CELL_OCCUPIED : w_rdata);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_value;

    a_out_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_RES))
        else $error("result appeared without a finished read");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("item taken while another is in work");

    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_rr <= r_r1) && (r_cc <= r_c1) && (r_rr >= r_r0))
        else $error("window scan left its window");

    a_write_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PWR) && w_mem_ctl.we |-> (SW'(r_cx) < r_side) && (SW'(r_cy) < r_side))
        else $error("point write outside the grid");

endmodule
